// ===== design/lhm_pkg.sv =====
// Shared types and constants for the leaky bucket health monitor.
package lhm_pkg;

	localparam int VEL_BITS = 16;
	localparam int CFG_BITS = 16;
	localparam int LIMIT_BITS = 15;
	localparam int LIMSQ_BITS = 2 * LIMIT_BITS;
	localparam int IDX_BITS = 8;

	localparam logic [CFG_BITS-1:0] DRAIN_RST = 16'd1638;
	localparam logic [CFG_BITS-1:0] FILL_RST = 16'd7864;
	localparam logic [CFG_BITS-1:0] THR_RST = 16'd24576;
	localparam logic [LIMSQ_BITS-1:0] LIMSQ_RST = 30'd65536;

	localparam logic [1:0] FENCE_OUTSIDE = 2'd1;
	localparam logic [1:0] FENCE_INACTIVE = 2'd2;

	typedef enum logic [IDX_BITS-1:0] {
		REG_DRAIN_RATE = 8'd0,
		REG_FILL_STEP = 8'd1,
		REG_ERROR_THRESHOLD = 8'd2,
		REG_SPEED_LIMIT = 8'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		HEALTH_WAITING = 2'd0,
		HEALTH_READY = 2'd1,
		HEALTH_ERROR = 2'd2
	} health_t;

	typedef struct packed {
		logic odom_arrived;
		logic nav_arrived;
		logic fence_arrived;
		logic signed [VEL_BITS-1:0] velocity_x;
		logic signed [VEL_BITS-1:0] velocity_y;
		logic [1:0] fence_status;
	} item_t;

	typedef struct packed {
		health_t health;
		logic odom_timeout;
		logic nav_timeout;
		logic fence_timeout;
		logic outside_fence;
		logic overspeed;
	} result_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] drain;
		logic [CFG_BITS-1:0] fill;
		logic [CFG_BITS-1:0] thr;
	} bkt_cfg_t;

	typedef struct packed {
		logic fire;
		logic run;
		logic clear;
	} bkt_ctl_t;

endpackage

// ===== design/lhm_bucket.sv =====
// One leaky bucket with its pending arrival flag.
module lhm_bucket #(
	parameter int LEVEL_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input lhm_pkg::bkt_ctl_t ctl,
	input lhm_pkg::bkt_cfg_t cfg,
	input logic arrived,
	output logic timeout
);

	localparam int CW = ((LEVEL_BITS > lhm_pkg::CFG_BITS) ? LEVEL_BITS : lhm_pkg::CFG_BITS) + 1;

	logic [LEVEL_BITS-1:0] level_q;
	logic pending_q;
	logic pend_n;
	logic [CW-1:0] lv_ext;
	logic [CW-1:0] drained;
	logic [CW-1:0] filled;
	logic [CW-1:0] full;
	logic [CW-1:0] clamped;

	always_comb begin
		pend_n = pending_q | arrived;
		lv_ext = CW'(level_q);
		full = CW'(1) << (LEVEL_BITS - 1);
		drained = (lv_ext > CW'(cfg.drain)) ? (lv_ext - CW'(cfg.drain)) : '0;
		filled = pend_n ? drained : (drained + CW'(cfg.fill));
		clamped = (filled > full) ? full : filled;
		timeout = (clamped >= CW'(cfg.thr));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			pending_q <= 1'b0;
		end else if (ctl.fire) begin
			pending_q <= ctl.clear ? 1'b0 : pend_n;
			if (ctl.run) begin
				level_q <= clamped[LEVEL_BITS-1:0];
			end
		end
	end

endmodule

// ===== design/lhm_check.sv =====
// Fence and speed check on the stored vehicle data.
module lhm_check (
	input logic signed [lhm_pkg::VEL_BITS-1:0] vx,
	input logic signed [lhm_pkg::VEL_BITS-1:0] vy,
	input logic [1:0] fence,
	input logic [lhm_pkg::LIMSQ_BITS-1:0] limsq,
	output logic outside,
	output logic overspeed
);

	localparam int MW = lhm_pkg::VEL_BITS + 1;
	localparam int SW = 2 * lhm_pkg::VEL_BITS;

	logic signed [MW-1:0] vxe;
	logic signed [MW-1:0] vye;
	logic [MW-1:0] ax;
	logic [MW-1:0] ay;
	logic [SW-1:0] sqx;
	logic [SW-1:0] sqy;
	logic [SW-1:0] sum;

	always_comb begin
		vxe = MW'(vx);
		vye = MW'(vy);
		ax = vxe[MW-1] ? MW'(-vxe) : MW'(vxe);
		ay = vye[MW-1] ? MW'(-vye) : MW'(vye);
		sqx = SW'(ax) * SW'(ax);
		sqy = SW'(ay) * SW'(ay);
		sum = sqx + sqy;
		outside = (fence == lhm_pkg::FENCE_OUTSIDE);
		overspeed = (fence == lhm_pkg::FENCE_INACTIVE) && (sum > SW'(limsq));
	end

endmodule

// ===== design/leaky_bucket_health_monitor_unit.sv =====
// Top level of the leaky bucket health monitor.
// A tick word is registered on entry and its result is then registered
// in the output register. Throughput: one tick word per cycle while the
// output is not stalled, set by the single compute stage.
// Reset clears buckets, pending and seen flags, stored data and registers
// to their defaults; no clearing pass.
module leaky_bucket_health_monitor_unit #(
	parameter int LEVEL_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input lhm_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output lhm_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lhm_pkg::IDX_BITS-1:0] cfg_index,
	input logic [lhm_pkg::CFG_BITS-1:0] cfg_data
);

	lhm_pkg::item_t item_s1;
	logic valid_s1;
	lhm_pkg::result_t result_q;
	logic result_valid_q;

	lhm_pkg::bkt_cfg_t bcfg_q;
	logic [lhm_pkg::LIMSQ_BITS-1:0] limsq_q;
	logic [lhm_pkg::LIMIT_BITS-1:0] lim;

	logic odom_seen_q;
	logic nav_seen_q;
	logic signed [lhm_pkg::VEL_BITS-1:0] vx_q;
	logic signed [lhm_pkg::VEL_BITS-1:0] vy_q;
	logic [1:0] fence_q;

	logic advance;
	logic fire;
	logic run;
	logic any_to;
	logic [2:0] arr;
	logic [2:0] to;
	logic odom_seen_n;
	logic nav_seen_n;
	logic signed [lhm_pkg::VEL_BITS-1:0] vx_n;
	logic signed [lhm_pkg::VEL_BITS-1:0] vy_n;
	logic [1:0] fence_n;
	logic outside;
	logic overspeed;
	lhm_pkg::bkt_ctl_t ctl;
	lhm_pkg::result_t res_n;

	assign cfg_ready = 1'b1;
	assign lim = cfg_data[lhm_pkg::LIMIT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcfg_q.drain <= lhm_pkg::DRAIN_RST;
			bcfg_q.fill <= lhm_pkg::FILL_RST;
			bcfg_q.thr <= lhm_pkg::THR_RST;
			limsq_q <= lhm_pkg::LIMSQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lhm_pkg::REG_DRAIN_RATE: bcfg_q.drain <= cfg_data;
				lhm_pkg::REG_FILL_STEP: bcfg_q.fill <= cfg_data;
				lhm_pkg::REG_ERROR_THRESHOLD: bcfg_q.thr <= cfg_data;
				lhm_pkg::REG_SPEED_LIMIT: limsq_q <=
					lhm_pkg::LIMSQ_BITS'(lim) * lhm_pkg::LIMSQ_BITS'(lim);
				default: ;
			endcase
		end
	end

	assign advance = !(result_valid_q && result_stall);
	assign item_stall = valid_s1 && !advance;
	assign fire = valid_s1 && advance;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		arr = {item_s1.fence_arrived, item_s1.nav_arrived, item_s1.odom_arrived};
		odom_seen_n = odom_seen_q | arr[0];
		nav_seen_n = nav_seen_q | arr[1];
		vx_n = arr[0] ? item_s1.velocity_x : vx_q;
		vy_n = arr[0] ? item_s1.velocity_y : vy_q;
		fence_n = arr[2] ? item_s1.fence_status : fence_q;
		run = odom_seen_n && nav_seen_n;
		any_to = |to;
		ctl.fire = fire;
		ctl.run = run;
		ctl.clear = run && !any_to;
	end

	for (genvar g = 0; g < 3; g++) begin : g_bkt
		lhm_bucket #(
			.LEVEL_BITS(LEVEL_BITS)
		) u_bucket (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.cfg(bcfg_q),
			.arrived(arr[g]),
			.timeout(to[g])
		);
	end

	lhm_check u_check (
		.vx(vx_n),
		.vy(vy_n),
		.fence(fence_n),
		.limsq(limsq_q),
		.outside(outside),
		.overspeed(overspeed)
	);

	always_comb begin
		res_n = '0;
		res_n.health = lhm_pkg::HEALTH_WAITING;
		if (run) begin
			res_n.odom_timeout = to[0];
			res_n.nav_timeout = to[1];
			res_n.fence_timeout = to[2];
			if (any_to) begin
				res_n.health = lhm_pkg::HEALTH_ERROR;
			end else if (outside) begin
				res_n.health = lhm_pkg::HEALTH_ERROR;
				res_n.outside_fence = 1'b1;
			end else if (overspeed) begin
				res_n.health = lhm_pkg::HEALTH_ERROR;
				res_n.overspeed = 1'b1;
			end else begin
				res_n.health = lhm_pkg::HEALTH_READY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odom_seen_q <= 1'b0;
			nav_seen_q <= 1'b0;
			vx_q <= '0;
			vy_q <= '0;
			fence_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				odom_seen_q <= odom_seen_n;
				nav_seen_q <= nav_seen_n;
				vx_q <= vx_n;
				vy_q <= vy_n;
				fence_q <= fence_n;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= res_n;
		end
	end

`ifndef SYNTHESIS
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> result_valid)
		else $error("processed word produced no result");

	a_waiting_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.health == lhm_pkg::HEALTH_WAITING) |->
		!(result.odom_timeout || result.nav_timeout || result.fence_timeout ||
		result.outside_fence || result.overspeed))
		else $error("waiting result carries flags");

	a_ready_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.health == lhm_pkg::HEALTH_READY) |->
		!(result.odom_timeout || result.nav_timeout || result.fence_timeout ||
		result.outside_fence || result.overspeed))
		else $error("ready result carries flags");

	a_single_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.outside_fence && result.overspeed))
		else $error("both data check causes set");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && result_valid_q && result_stall |-> item_stall)
		else $error("input not stalled with both stages full");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the leaky bucket health monitor: directed and random ticks.
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_TIME = 4;
	localparam logic [16:0] LEVEL_FULL = 17'd32768;
	localparam logic [lhm_pkg::LIMIT_BITS-1:0] LIMIT_RST = 15'd256;
	localparam logic [1:0] FENCE_INSIDE = 2'd0;
	localparam logic [1:0] FENCE_SPARE = 2'd3;
	localparam logic [lhm_pkg::IDX_BITS-1:0] REG_NONE = 8'd77;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	lhm_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	lhm_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lhm_pkg::IDX_BITS-1:0] cfg_index = '0;
	logic [lhm_pkg::CFG_BITS-1:0] cfg_data = '0;

	lhm_pkg::item_t pending_ticks[$];
	lhm_pkg::result_t due_results[$];

	// predictor copy of registers and state
	logic [lhm_pkg::CFG_BITS-1:0] drain_q = lhm_pkg::DRAIN_RST;
	logic [lhm_pkg::CFG_BITS-1:0] fill_q = lhm_pkg::FILL_RST;
	logic [lhm_pkg::CFG_BITS-1:0] thr_q = lhm_pkg::THR_RST;
	logic [lhm_pkg::LIMIT_BITS-1:0] limit_q = LIMIT_RST;
	logic odom_seen = 1'b0;
	logic nav_seen = 1'b0;
	logic [2:0] arr_pend = '0;
	logic [15:0] bucket[3] = '{16'd0, 16'd0, 16'd0};
	logic signed [lhm_pkg::VEL_BITS-1:0] vx_q = '0;
	logic signed [lhm_pkg::VEL_BITS-1:0] vy_q = '0;
	logic [1:0] fence_q = FENCE_INSIDE;

	int send_idle_pct = 32;
	int recv_idle_pct = 64;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;
	int ticks_sent = 0;
	int words_seen = 0;
	int reg_writes = 0;
	int tally[3] = '{0, 0, 0};
	int timeouts_seen = 0;
	int outside_seen = 0;
	int overspeed_seen = 0;

	leaky_bucket_health_monitor_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [33:0] vel_sq(logic signed [lhm_pkg::VEL_BITS-1:0] v);
		logic signed [33:0] e;
		e = 34'(v);
		if (e < 0)
			e = -e;
		return e * e;
	endfunction

	function automatic lhm_pkg::result_t health_tick(lhm_pkg::item_t w);
		lhm_pkg::result_t r;
		logic [17:0] lvl;
		logic [2:0] late;
		logic [33:0] lim;
		r = '0;
		late = '0;
		if (w.odom_arrived) begin
			odom_seen = 1'b1;
			vx_q = w.velocity_x;
			vy_q = w.velocity_y;
		end
		if (w.nav_arrived)
			nav_seen = 1'b1;
		if (w.fence_arrived)
			fence_q = w.fence_status;
		arr_pend = arr_pend | {w.fence_arrived, w.nav_arrived, w.odom_arrived};
		if (!odom_seen || !nav_seen) begin
			r.health = lhm_pkg::HEALTH_WAITING;
			return r;
		end
		for (int s = 0; s < 3; s++) begin
			lvl = (bucket[s] > drain_q) ? 18'(bucket[s] - drain_q) : 18'd0;
			if (!arr_pend[s])
				lvl = lvl + fill_q;
			if (lvl > LEVEL_FULL)
				lvl = LEVEL_FULL;
			bucket[s] = lvl[15:0];
			late[s] = (lvl >= thr_q);
		end
		r.odom_timeout = late[0];
		r.nav_timeout = late[1];
		r.fence_timeout = late[2];
		if (|late) begin
			r.health = lhm_pkg::HEALTH_ERROR;
			return r;
		end
		r.health = lhm_pkg::HEALTH_READY;
		lim = 34'(limit_q);
		if (fence_q == lhm_pkg::FENCE_OUTSIDE) begin
			r.health = lhm_pkg::HEALTH_ERROR;
			r.outside_fence = 1'b1;
		end else if (fence_q == lhm_pkg::FENCE_INACTIVE &&
				vel_sq(vx_q) + vel_sq(vy_q) > lim * lim) begin
			r.health = lhm_pkg::HEALTH_ERROR;
			r.overspeed = 1'b1;
		end
		arr_pend = '0;
		return r;
	endfunction

	function automatic lhm_pkg::item_t random_tick(int pct);
		lhm_pkg::item_t w;
		int span;
		int roll;
		if ($urandom_range(9) == 0) begin
			w.odom_arrived = 1'($urandom);
			w.nav_arrived = 1'($urandom);
			w.fence_arrived = 1'($urandom);
			w.velocity_x = 16'($urandom);
			w.velocity_y = 16'($urandom);
			w.fence_status = 2'($urandom);
			return w;
		end
		w.odom_arrived = ($urandom_range(99) < pct);
		w.nav_arrived = ($urandom_range(99) < pct);
		w.fence_arrived = ($urandom_range(99) < pct);
		span = (int'(limit_q) * 3) / 4 + 2;
		w.velocity_x = 16'($urandom_range(2 * span) - span);
		w.velocity_y = 16'($urandom_range(2 * span) - span);
		if ($urandom_range(3) == 0)
			w.velocity_x = 16'($urandom);
		if ($urandom_range(3) == 0)
			w.velocity_y = 16'($urandom);
		roll = $urandom_range(19);
		if (roll < 8)
			w.fence_status = FENCE_INSIDE;
		else if (roll < 12)
			w.fence_status = lhm_pkg::FENCE_OUTSIDE;
		else if (roll < 19)
			w.fence_status = lhm_pkg::FENCE_INACTIVE;
		else
			w.fence_status = FENCE_SPARE;
		return w;
	endfunction

	task automatic add_tick(logic o, logic n, logic f, logic signed [lhm_pkg::VEL_BITS-1:0] vx,
			logic signed [lhm_pkg::VEL_BITS-1:0] vy, logic [1:0] fs);
		lhm_pkg::item_t w;
		w.odom_arrived = o;
		w.nav_arrived = n;
		w.fence_arrived = f;
		w.velocity_x = vx;
		w.velocity_y = vy;
		w.fence_status = fs;
		pending_ticks.push_back(w);
	endtask

	task automatic settle();
		while (pending_ticks.size() != 0 || item_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TIME) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [lhm_pkg::IDX_BITS-1:0] idx,
			logic [lhm_pkg::CFG_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			lhm_pkg::REG_DRAIN_RATE: drain_q = val;
			lhm_pkg::REG_FILL_STEP: fill_q = val;
			lhm_pkg::REG_ERROR_THRESHOLD: thr_q = val;
			lhm_pkg::REG_SPEED_LIMIT: limit_q = val[lhm_pkg::LIMIT_BITS-1:0];
			default: ;
		endcase
		reg_writes++;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_limits(logic [lhm_pkg::CFG_BITS-1:0] drain,
			logic [lhm_pkg::CFG_BITS-1:0] fill, logic [lhm_pkg::CFG_BITS-1:0] thr,
			logic [lhm_pkg::CFG_BITS-1:0] lim);
		write_reg(lhm_pkg::REG_DRAIN_RATE, drain);
		write_reg(lhm_pkg::REG_FILL_STEP, fill);
		write_reg(lhm_pkg::REG_ERROR_THRESHOLD, thr);
		write_reg(lhm_pkg::REG_SPEED_LIMIT, lim);
	endtask

	task automatic run_ticks(int n);
		for (int k = 0; k < n; k++)
			pending_ticks.push_back(random_tick(((k / 40) % 2) ? 55 : 92));
		settle();
	endtask

	task automatic check_field(string what, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				due_results.size());
			$display("leaky_bucket_health_monitor_unit test failed");
			$finish;
		end
	end

	// tick driver
	always @(posedge clk) begin
		lhm_pkg::item_t nxt;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				due_results.push_back(health_tick(item));
				ticks_sent++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_ticks.pop_front();
					item <= nxt;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		lhm_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				words_seen++;
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word %h", $time, result);
				end else begin
					want = due_results.pop_front();
					tally[want.health]++;
					if (want.odom_timeout || want.nav_timeout || want.fence_timeout)
						timeouts_seen++;
					outside_seen += want.outside_fence;
					overspeed_seen += want.overspeed;
					check_field("health", want.health, result.health);
					check_field("odom_timeout", want.odom_timeout, result.odom_timeout);
					check_field("nav_timeout", want.nav_timeout, result.nav_timeout);
					check_field("fence_timeout", want.fence_timeout, result.fence_timeout);
					check_field("outside_fence", want.outside_fence, result.outside_fence);
					check_field("overspeed", want.overspeed, result.overspeed);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_tick(1'b0, 1'b0, 1'b0, 16'sd100, 16'sd100, lhm_pkg::FENCE_OUTSIDE);
		add_tick(1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0, lhm_pkg::FENCE_OUTSIDE);
		add_tick(1'b1, 1'b0, 1'b0, -16'sd32768, 16'sd32767, lhm_pkg::FENCE_INACTIVE);
		add_tick(1'b0, 1'b1, 1'b0, 16'sd0, 16'sd0, FENCE_INSIDE);
		add_tick(1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, FENCE_INSIDE);
		add_tick(1'b1, 1'b1, 1'b1, 16'sd256, 16'sd0, lhm_pkg::FENCE_INACTIVE);
		add_tick(1'b1, 1'b1, 1'b1, 16'sd256, 16'sd1, lhm_pkg::FENCE_INACTIVE);
		add_tick(1'b1, 1'b1, 1'b1, -16'sd32768, -16'sd32768, FENCE_SPARE);
		add_tick(1'b1, 1'b1, 1'b1, -16'sd32768, -16'sd32768, lhm_pkg::FENCE_INACTIVE);
		repeat (5)
			add_tick(1'b0, 1'b0, 1'b0, 16'sd32767, 16'sd32767, lhm_pkg::FENCE_OUTSIDE);
		add_tick(1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0, lhm_pkg::FENCE_OUTSIDE);
		repeat (6)
			add_tick(1'b1, 1'b1, 1'b1, 16'sd10, -16'sd10, FENCE_INSIDE);
		add_tick(1'b1, 1'b1, 1'b1, -16'sd181, 16'sd181, lhm_pkg::FENCE_INACTIVE);
		add_tick(1'b1, 1'b1, 1'b1, -16'sd182, 16'sd182, lhm_pkg::FENCE_INACTIVE);
		add_tick(1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, lhm_pkg::FENCE_OUTSIDE);
		settle();
		write_reg(REG_NONE, 16'd0);

		run_ticks(250);
		set_limits(16'd0, 16'hFFFF, 16'hFFFF, 16'd32767);
		run_ticks(250);

		send_idle_pct = 64;
		recv_idle_pct = 32;
		set_limits(16'hFFFF, 16'd0, 16'd0, 16'd0);
		run_ticks(250);
		set_limits(16'd3000, 16'd9000, 16'd32768, 16'd128);
		run_ticks(250);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limits(16'd800, 16'd4000, 16'd16000, 16'd1000);
		run_ticks(125);
		run_ticks(125);
		set_limits(16'hFFFF, 16'hFFFF, 16'd32768, 16'hFFFF);
		hold_req = 1'b1;
		run_ticks(250);
		set_limits(lhm_pkg::DRAIN_RST, lhm_pkg::FILL_RST, lhm_pkg::THR_RST, 16'(LIMIT_RST));
		run_ticks(250);

		repeat (DRAIN_TIME) @(posedge clk);
		$display("Ran %0d ticks through %0d register writes; %0d result words checked",
			ticks_sent, reg_writes, words_seen);
		$display("waiting %0d, ready %0d, error %0d (timeout %0d, outside %0d, overspeed %0d)",
			tally[lhm_pkg::HEALTH_WAITING], tally[lhm_pkg::HEALTH_READY],
			tally[lhm_pkg::HEALTH_ERROR], timeouts_seen, outside_seen, overspeed_seen);
		if (errors == 0)
			$display("leaky_bucket_health_monitor_unit test passed");
		else
			$display("leaky_bucket_health_monitor_unit test failed");
		$finish;
	end

endmodule
